[hdl/stack_allocator_with_alignment_macros.svh]
// assertion macros for the stack allocator
// used by stack_allocator_with_alignment.sv, expects clk_i and rst_ni in scope
`ifndef STACK_ALLOCATOR_WITH_ALIGNMENT_MACROS_SVH
`define STACK_ALLOCATOR_WITH_ALIGNMENT_MACROS_SVH

// property that must hold at every edge out of reset
`define SAA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define SAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/saa_pkg.sv]
// shared types and constants for the stack allocator
// no dependencies
`timescale 1ns / 1ps

package saa_pkg;

  localparam int unsigned RecordDepth = 64;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned DataW       = 32;
  localparam int unsigned AlignW      = 4;
  localparam int unsigned CntW        = $clog2(RecordDepth + 1);
  localparam int unsigned IdxW        = (RecordDepth > 1) ? $clog2(RecordDepth) : 1;
  localparam int unsigned CfgAddrW    = 1;

  // result beat layout, lowest bit first
  localparam int unsigned ResBits  = 2 + 4 * DataW + 1 + CntW;
  localparam int unsigned ResBytes = (ResBits + 7) / 8;
  localparam int unsigned ResW     = ResBytes * 8;

  localparam int unsigned ReqBits  = DataW + AlignW;
  localparam int unsigned ReqW     = ((ReqBits + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_BASE     = 1'd0,
    REG_CAPACITY = 1'd1
  } cfg_reg_e;

endpackage

[hdl/stack_allocator_with_alignment.sv]
// stack allocator with aligned pushes, top level
// depends on saa_pkg and stack_allocator_with_alignment_macros.svh
// an input beat passes the input register, then the result register, to the result beat
// throughput: one request per cycle, sustained while the result side takes beats
// state update is one add of offset, padding and size plus a capacity compare
// reset: offset, live count, pipeline valids and both registers clear to zero;
// the record memory is not cleared; data read from entries at or above the live count is not used
`timescale 1ns / 1ps
`include "stack_allocator_with_alignment_macros.svh"

module stack_allocator_with_alignment (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [saa_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [saa_pkg::DataW-1:0]          cfg_wdata_i,
  // request stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [saa_pkg::ReqW-1:0]           s_axis_tdata_i,  // alloc_size, align_log2
  input  logic [1:0]                         s_axis_tuser_i,  // req_type
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // status, alloc_address, used_bytes, remaining_bytes, top_offset, top_valid, live_count
  output logic [saa_pkg::ResW-1:0]           m_axis_tdata_o
);

  localparam int unsigned DataW  = saa_pkg::DataW;
  localparam int unsigned AddrW  = saa_pkg::AddrW;
  localparam int unsigned AlignW = saa_pkg::AlignW;
  localparam int unsigned CntW   = saa_pkg::CntW;
  localparam int unsigned IdxW   = saa_pkg::IdxW;
  localparam int unsigned SumW   = DataW + 2;

  // configuration registers
  logic [DataW-1:0] base_q, cap_q;

  // input register
  logic                      in_valid_q;
  saa_pkg::req_e             in_req_q;
  logic [DataW-1:0]          in_size_q;
  logic [AlignW-1:0]         in_lg_q;

  // allocator state: top and next-below record held in flops, the rest in memory
  logic [DataW-1:0] off_q, off_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] top_q, top_d;
  logic [DataW-1:0] below_q, below_d;
  logic [DataW-1:0] rd_q;
  logic [DataW-1:0] rec_mem [saa_pkg::RecordDepth];
  logic [IdxW-1:0]  rd_addr;
  logic             mem_we;

  // result register
  logic                 out_valid_q;
  logic [saa_pkg::ResW-1:0] out_data_q, out_data_d;

  logic advance;

  // datapath
  logic [AddrW-1:0]  cur_addr, amask, pad, grant_addr;
  logic [SumW-1:0]   total;
  logic              oom, full, push_ok;
  saa_pkg::status_e  status;
  logic [DataW-1:0]  addr_out, remaining, top_out;

  // push outcomes seen by the checks
  logic push_go, push_oom;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cap_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        saa_pkg::REG_BASE:     base_q <= cfg_wdata_i;
        saa_pkg::REG_CAPACITY: cap_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register, refilled whenever the held beat moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q  <= saa_pkg::req_e'(s_axis_tuser_i);
      in_size_q <= s_axis_tdata_i[DataW-1:0];
      in_lg_q   <= s_axis_tdata_i[DataW+AlignW-1:DataW];
    end
  end

  // alignment padding from the absolute address, wraps at the address width
  always_comb begin
    cur_addr   = AddrW'(base_q) + AddrW'(off_q);
    amask      = (AddrW'(1) << in_lg_q) - AddrW'(1);
    pad        = (~cur_addr + AddrW'(1)) & amask;
    grant_addr = cur_addr + pad;
    total      = SumW'(off_q) + SumW'(pad) + SumW'(in_size_q);
    oom        = total > SumW'(cap_q);
    full       = cnt_q == CntW'(saa_pkg::RecordDepth);
    push_ok    = !oom && !full;
  end

  // next state and status
  always_comb begin
    off_d    = off_q;
    cnt_d    = cnt_q;
    top_d    = top_q;
    below_d  = below_q;
    mem_we   = 1'b0;
    status   = saa_pkg::ST_OK;
    addr_out = '0;
    if (advance) begin
      unique case (in_req_q)
        saa_pkg::REQ_PUSH: begin
          if (oom) begin
            status = saa_pkg::ST_OOM;
          end else if (full) begin
            status = saa_pkg::ST_FULL;
          end else begin
            mem_we   = 1'b1;
            off_d    = total[DataW-1:0];
            cnt_d    = cnt_q + CntW'(1);
            top_d    = off_q;
            below_d  = top_q;
            addr_out = grant_addr[DataW-1:0];
          end
        end
        saa_pkg::REQ_POP: begin
          if (cnt_q == '0) begin
            status = saa_pkg::ST_EMPTY;
          end else begin
            off_d   = top_q;
            cnt_d   = cnt_q - CntW'(1);
            top_d   = below_q;
            below_d = rd_q;
          end
        end
        saa_pkg::REQ_CLEAR: begin
          off_d = '0;
          cnt_d = '0;
        end
        default: ;
      endcase
    end
  end

  // prefetch the record two below the new top so a following pop has it ready
  always_comb begin
    if (cnt_d >= CntW'(3)) begin
      rd_addr = IdxW'(cnt_d - CntW'(3));
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[IdxW'(cnt_q)] <= off_q;
    end
    rd_q <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      cnt_q <= '0;
    end else begin
      off_q <= off_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    below_q <= below_d;
  end

  // report fields describe the state after the request
  always_comb begin
    remaining  = (cap_q > off_d) ? (cap_q - off_d) : '0;
    top_out    = (cnt_d != '0) ? top_d : '0;
    out_data_d = saa_pkg::ResW'({cnt_d, (cnt_d != '0), top_out, remaining, off_d,
                                 addr_out, status});
  end

  // result register, holds until the sink takes the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign push_go  = advance && in_req_q == saa_pkg::REQ_PUSH && push_ok;
  assign push_oom = advance && in_req_q == saa_pkg::REQ_PUSH && oom;

  `SAA_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntW'(saa_pkg::RecordDepth), "live count over depth")
  `SAA_ASSERT_NEXT(a_push_grows, push_go, cnt_q == $past(cnt_q) + CntW'(1), "push did not count")
  `SAA_ASSERT_NEXT(a_oom_holds, push_oom, $stable(off_q) && $stable(cnt_q), "failed push moved")

endmodule
